>>> design/key_press_event_detector_assert.svh
// Assertion macros for the key press event detector.
`ifndef KEY_PRESS_EVENT_DETECTOR_ASSERT_SVH
`define KEY_PRESS_EVENT_DETECTOR_ASSERT_SVH

// Checked only while the block is out of reset.
`define KPED_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every edge, reset included.
`define KPED_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> design/kped_pkg.sv
`default_nettype none
package kped_pkg;

  localparam int CntW  = 16;
  localparam int OffW  = 8;
  localparam int KeyW  = 3;
  localparam int CodeW = 8;
  localparam int CfgAddrW = 3;
  localparam int CfgDataW = 16;

  localparam logic [CfgAddrW-1:0] CFG_LONG_PRESS_TICKS  = 3'd0;
  localparam logic [CfgAddrW-1:0] CFG_REPEAT_TICKS      = 3'd1;
  localparam logic [CfgAddrW-1:0] CFG_FIRST_LONG_OFFSET = 3'd2;
  localparam logic [CfgAddrW-1:0] CFG_REPEAT_OFFSET     = 3'd3;
  localparam logic [CfgAddrW-1:0] CFG_RELEASE_OFFSET    = 3'd4;

  localparam logic [CntW-1:0] LONG_PRESS_TICKS_RST  = 16'd200;
  localparam logic [CntW-1:0] REPEAT_TICKS_RST      = 16'd30;
  localparam logic [OffW-1:0] FIRST_LONG_OFFSET_RST = 8'd16;
  localparam logic [OffW-1:0] REPEAT_OFFSET_RST     = 8'd32;
  localparam logic [OffW-1:0] RELEASE_OFFSET_RST    = 8'd48;

  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_SHORT = 2'd1;
  localparam logic [1:0] PH_LONG  = 2'd2;

  typedef struct packed {
    logic [CntW-1:0] long_press_ticks;
    logic [CntW-1:0] repeat_ticks;
    logic [OffW-1:0] first_long_offset;
    logic [OffW-1:0] repeat_offset;
    logic [OffW-1:0] release_offset;
  } cfg_t;

  function automatic logic [CntW-1:0] sat_inc(input logic [CntW-1:0] c);
    sat_inc = (c == {CntW{1'b1}}) ? c : c + 1'b1;
  endfunction

endpackage
`default_nettype wire

>>> design/key_press_event_detector.sv
// Channel  | Direction | Payload bits (lowest first)
// ---------+-----------+---------------------------------------------------
// in_      | slave     | up_level, down_level, confirm_level, zero padding
// out_     | master    | key_code
// cfg_     | write     | register index, data up to 16 bits
//
// Each scan tick passes through the input register and then through the
// state update that loads the result register.
// One tick is taken in every cycle while results are drained.
// Reset is synchronous and restores the state and config registers to defaults.
// A stalled result holds the state update; the input register then holds
// one further tick before in_tready falls.
`default_nettype none
module key_press_event_detector (
  input  wire                            clk,
  input  wire                            rst_n,
  input  wire                            in_tvalid,
  output logic                           in_tready,
  input  wire  [7:0]                     in_tdata,   // up_level, down_level, confirm_level
  output logic                           out_tvalid,
  input  wire                            out_tready,
  output logic [7:0]                     out_tdata,  // key_code
  input  wire                            cfg_we,
  input  wire  [kped_pkg::CfgAddrW-1:0]  cfg_addr,
  input  wire  [kped_pkg::CfgDataW-1:0]  cfg_wdata
);
  import kped_pkg::*;

  cfg_t            cfg;
  logic            key_valid;
  logic [KeyW-1:0] key;
  logic            fire;

  kped_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  kped_in u_in (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .fire      (fire),
    .key_valid (key_valid),
    .key       (key)
  );

  kped_fsm u_fsm (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .key_valid  (key_valid),
    .key        (key),
    .fire       (fire),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule
`default_nettype wire

>>> design/kped_cfg.sv
`default_nettype none
module kped_cfg (
  input  wire                            clk,
  input  wire                            rst_n,
  input  wire                            cfg_we,
  input  wire  [kped_pkg::CfgAddrW-1:0]  cfg_addr,
  input  wire  [kped_pkg::CfgDataW-1:0]  cfg_wdata,
  output kped_pkg::cfg_t                 cfg
);
  import kped_pkg::*;

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.long_press_ticks  <= LONG_PRESS_TICKS_RST;
      cfg_r.repeat_ticks      <= REPEAT_TICKS_RST;
      cfg_r.first_long_offset <= FIRST_LONG_OFFSET_RST;
      cfg_r.repeat_offset     <= REPEAT_OFFSET_RST;
      cfg_r.release_offset    <= RELEASE_OFFSET_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_LONG_PRESS_TICKS:  cfg_r.long_press_ticks  <= cfg_wdata[CntW-1:0];
        CFG_REPEAT_TICKS:      cfg_r.repeat_ticks      <= cfg_wdata[CntW-1:0];
        CFG_FIRST_LONG_OFFSET: cfg_r.first_long_offset <= cfg_wdata[OffW-1:0];
        CFG_REPEAT_OFFSET:     cfg_r.repeat_offset     <= cfg_wdata[OffW-1:0];
        CFG_RELEASE_OFFSET:    cfg_r.release_offset    <= cfg_wdata[OffW-1:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule
`default_nettype wire

>>> design/kped_in.sv
`default_nettype none
module kped_in (
  input  wire                        clk,
  input  wire                        rst_n,
  input  wire                        in_tvalid,
  output logic                       in_tready,
  input  wire  [7:0]                 in_tdata,
  input  wire                        fire,
  output logic                       key_valid,
  output logic [kped_pkg::KeyW-1:0]  key
);
  import kped_pkg::*;

  logic            in_v_r;
  logic [KeyW-1:0] key_r;

  // The pins are turned into the active-high key value on the way in.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_tready) begin
      in_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      key_r <= {in_tdata[2], ~in_tdata[1], ~in_tdata[0]};
    end
  end

  assign in_tready = !in_v_r || fire;
  assign key_valid = in_v_r;
  assign key       = key_r;

endmodule
`default_nettype wire

>>> design/kped_fsm.sv
`default_nettype none
module kped_fsm (
  input  wire                        clk,
  input  wire                        rst_n,
  input  kped_pkg::cfg_t             cfg,
  input  wire                        key_valid,
  input  wire  [kped_pkg::KeyW-1:0]  key,
  output logic                       fire,
  output logic                       out_tvalid,
  input  wire                        out_tready,
  output logic [7:0]                 out_tdata
);
  import kped_pkg::*;

  logic [1:0]       phase_r, phase_nxt;
  logic [KeyW-1:0]  held_r, held_nxt;
  logic [CntW-1:0]  short_r, short_nxt;
  logic [CntW-1:0]  long_r, long_nxt;
  logic             out_v_r;
  logic [CodeW-1:0] code_r;
  logic             emit;
  logic [CodeW-1:0] code;
  logic [CodeW-1:0] held_ext;

  assign fire     = key_valid && (!out_v_r || out_tready);
  assign held_ext = {{(CodeW-KeyW){1'b0}}, held_r};

  always_comb begin
    phase_nxt = phase_r;
    held_nxt  = held_r;
    long_nxt  = (phase_r == PH_LONG)  ? sat_inc(long_r)  : '0;
    short_nxt = (phase_r == PH_SHORT) ? sat_inc(short_r) : '0;
    emit      = 1'b0;
    code      = held_ext;
    case (phase_r)
      PH_IDLE: begin
        if (key != '0) begin
          phase_nxt = PH_SHORT;
          held_nxt  = key;
        end
      end
      PH_SHORT: begin
        if (key == held_r) begin
          if (short_nxt >= cfg.long_press_ticks) begin
            short_nxt = '0;
            emit      = 1'b1;
            code      = held_ext + cfg.first_long_offset;
            phase_nxt = PH_LONG;
          end
        end else begin
          emit      = 1'b1;
          code      = held_ext;
          held_nxt  = '0;
          phase_nxt = PH_IDLE;
        end
      end
      PH_LONG: begin
        if (key == held_r) begin
          if (long_nxt >= cfg.repeat_ticks) begin
            emit     = 1'b1;
            code     = held_ext + cfg.repeat_offset;
            long_nxt = '0;
          end
        end else begin
          emit      = 1'b1;
          code      = held_ext + cfg.release_offset;
          phase_nxt = PH_IDLE;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      held_r  <= '0;
      short_r <= '0;
      long_r  <= '0;
      out_v_r <= 1'b0;
    end else begin
      if (fire) begin
        phase_r <= phase_nxt;
        held_r  <= held_nxt;
        short_r <= short_nxt;
        long_r  <= long_nxt;
        out_v_r <= emit;
      end else if (out_tready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire && emit) begin
      code_r <= code;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = code_r;

endmodule
`default_nettype wire

>>> design/kped_checker.sv
`default_nettype none
`include "key_press_event_detector_assert.svh"
module kped_checker (
  input wire       clk,
  input wire       rst_n,
  input wire       in_tvalid,
  input wire       in_tready,
  input wire       out_tvalid,
  input wire       out_tready,
  input wire [7:0] out_tdata
);

  `KPED_ASSERT(a_out_hold, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata), "result changed while stalled")
  `KPED_ASSERT_ALWAYS(a_rst_clear, !rst_n |=> !out_tvalid, "result pending after reset")
  `KPED_ASSERT(a_ready_when_empty, !out_tvalid |-> in_tready, "input blocked with no result pending")
  `KPED_ASSERT(a_result_has_cause, $rose(out_tvalid) |-> $past(in_tvalid && in_tready, 2), "result without an input transfer two cycles before")

endmodule

bind key_press_event_detector kped_checker u_kped_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
`default_nettype wire

>>> sim/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import kped_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 4;
  localparam int HOLD_MAX = 250;

  localparam logic [KeyW-1:0] KEY_NONE = 3'b000;
  localparam logic [KeyW-1:0] KEY_UP   = 3'b001;
  localparam logic [KeyW-1:0] KEY_DN   = 3'b010;
  localparam logic [KeyW-1:0] KEY_OK   = 3'b100;
  localparam logic [KeyW-1:0] KEY_ALL  = 3'b111;

  typedef enum logic [1:0] {ROW_CHECK, ROW_QUIET, ROW_CODE, ROW_REG} row_kind_t;

  typedef struct packed {
    row_kind_t            kind;
    logic [CfgAddrW-1:0]  addr;
    logic [KeyW-1:0]      key;
    logic [CfgDataW-1:0]  arg;
    logic [CodeW-1:0]     code;
  } dir_row_t;

  localparam int DIR_N = 28;
  localparam dir_row_t DIR_ROWS [DIR_N] = '{
    '{ROW_QUIET, '0, KEY_NONE, '0, 8'd0},
    '{ROW_QUIET, '0, KEY_UP, '0, 8'd0},
    '{ROW_CODE,  '0, KEY_NONE, '0, 8'd1},
    '{ROW_QUIET, '0, KEY_DN, '0, 8'd0},
    '{ROW_CODE,  '0, KEY_NONE, '0, 8'd2},
    '{ROW_QUIET, '0, KEY_OK, '0, 8'd0},
    '{ROW_CODE,  '0, KEY_UP, '0, 8'd4},
    '{ROW_QUIET, '0, KEY_NONE, '0, 8'd0},
    '{ROW_QUIET, '0, KEY_ALL, '0, 8'd0},
    '{ROW_CODE,  '0, KEY_NONE, '0, 8'd7},
    '{ROW_REG,   CFG_LONG_PRESS_TICKS, KEY_NONE, 16'd1, 8'd0},
    '{ROW_REG,   CFG_REPEAT_TICKS, KEY_NONE, 16'd1, 8'd0},
    '{ROW_REG,   CFG_FIRST_LONG_OFFSET, KEY_NONE, 16'd255, 8'd0},
    '{ROW_REG,   CFG_REPEAT_OFFSET, KEY_NONE, 16'd0, 8'd0},
    '{ROW_REG,   CFG_RELEASE_OFFSET, KEY_NONE, 16'd255, 8'd0},
    '{ROW_QUIET, '0, KEY_ALL, '0, 8'd0},
    '{ROW_CHECK, '0, KEY_ALL, '0, 8'd0},
    '{ROW_CHECK, '0, KEY_ALL, '0, 8'd0},
    '{ROW_CHECK, '0, KEY_UP | KEY_DN, '0, 8'd0},
    '{ROW_CHECK, '0, KEY_UP | KEY_DN, '0, 8'd0},
    '{ROW_CHECK, '0, KEY_UP | KEY_DN, '0, 8'd0},
    '{ROW_CHECK, '0, KEY_NONE, '0, 8'd0},
    '{ROW_REG,   CFG_LONG_PRESS_TICKS, KEY_NONE, 16'd0, 8'd0},
    '{ROW_REG,   CFG_REPEAT_TICKS, KEY_NONE, 16'd0, 8'd0},
    '{ROW_CHECK, '0, KEY_UP | KEY_OK, '0, 8'd0},
    '{ROW_CHECK, '0, KEY_UP | KEY_OK, '0, 8'd0},
    '{ROW_CHECK, '0, KEY_UP | KEY_OK, '0, 8'd0},
    '{ROW_CHECK, '0, KEY_NONE, '0, 8'd0}
  };

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_tvalid = 1'b0;
  logic                 in_tready;
  logic [7:0]           in_tdata = 8'h03;
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [7:0]           out_tdata;
  logic                 cfg_we = 1'b0;
  logic [CfgAddrW-1:0]  cfg_addr = '0;
  logic [CfgDataW-1:0]  cfg_wdata = '0;

  // Key press model state and register copy.
  cfg_t                 kp_cfg;
  logic [1:0]           press_ph;
  logic [KeyW-1:0]      held_key;
  logic [CntW-1:0]      short_ticks;
  logic [CntW-1:0]      long_ticks;

  logic [CodeW-1:0]     pending_codes [$];
  logic [CodeW-1:0]     want_code;
  int                   key_errors = 0;
  int                   codes_checked = 0;
  int                   ticks_sent = 0;
  int                   reg_writes = 0;
  int                   idle_cycles = 0;
  int                   burst_left = 0;
  int                   rx_left = 0;

  key_press_event_detector DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic scan_tick(input logic [2:0] levels, output bit fires,
                           output logic [CodeW-1:0] code);
    logic [KeyW-1:0] key;
    key = {levels[2], ~levels[1], ~levels[0]};
    fires = 1'b0;
    code = '0;
    long_ticks = (press_ph != PH_LONG) ? '0 :
                 (long_ticks == {CntW{1'b1}}) ? long_ticks : long_ticks + 1'b1;
    short_ticks = (press_ph != PH_SHORT) ? '0 :
                  (short_ticks == {CntW{1'b1}}) ? short_ticks : short_ticks + 1'b1;
    case (press_ph)
      PH_IDLE: begin
        if (key != KEY_NONE) begin
          press_ph = PH_SHORT;
          held_key = key;
        end
      end
      PH_SHORT: begin
        if (key == held_key) begin
          if (short_ticks >= kp_cfg.long_press_ticks) begin
            short_ticks = '0;
            code = {5'b0, held_key} + kp_cfg.first_long_offset;
            fires = 1'b1;
            press_ph = PH_LONG;
          end
        end else begin
          code = {5'b0, held_key};
          fires = 1'b1;
          held_key = KEY_NONE;
          press_ph = PH_IDLE;
        end
      end
      PH_LONG: begin
        if (key == held_key) begin
          if (long_ticks >= kp_cfg.repeat_ticks) begin
            code = {5'b0, held_key} + kp_cfg.repeat_offset;
            fires = 1'b1;
            long_ticks = '0;
          end
        end else begin
          code = {5'b0, held_key} + kp_cfg.release_offset;
          fires = 1'b1;
          press_ph = PH_IDLE;
        end
      end
      default: begin
        short_ticks = '0;
        long_ticks = '0;
      end
    endcase
  endtask

  task automatic send_key(input logic [KeyW-1:0] key, input row_kind_t mode,
                          input logic [CodeW-1:0] typed_code);
    bit fires;
    logic [CodeW-1:0] code;
    in_tvalid <= 1'b1;
    in_tdata <= {5'b0, key[2], ~key[1], ~key[0]};
    do @(posedge clk); while (!in_tready);
    scan_tick(in_tdata[2:0], fires, code);
    ticks_sent++;
    if (mode == ROW_CODE) begin
      pending_codes.push_back(typed_code);
    end else if (mode == ROW_CHECK && fires) begin
      pending_codes.push_back(code);
    end
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_tvalid <= 1'b0;
      repeat (($urandom_range(0, 7) == 0) ? $urandom_range(15, 40) : $urandom_range(1, 5))
        @(posedge clk);
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 400)
                                                : $urandom_range(0, 12);
    end
  endtask

  task automatic write_reg(input logic [CfgAddrW-1:0] addr, input logic [CfgDataW-1:0] val);
    in_tvalid <= 1'b0;
    while (pending_codes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= addr;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (addr)
      CFG_LONG_PRESS_TICKS:  kp_cfg.long_press_ticks = val;
      CFG_REPEAT_TICKS:      kp_cfg.repeat_ticks = val;
      CFG_FIRST_LONG_OFFSET: kp_cfg.first_long_offset = val[OffW-1:0];
      CFG_REPEAT_OFFSET:     kp_cfg.repeat_offset = val[OffW-1:0];
      CFG_RELEASE_OFFSET:    kp_cfg.release_offset = val[OffW-1:0];
      default: ;
    endcase
    reg_writes++;
  endtask

  task automatic set_registers(input int long_ticks_val, input int repeat_ticks_val,
                               input int first_off, input int repeat_off, input int release_off);
    write_reg(CFG_LONG_PRESS_TICKS, CfgDataW'(long_ticks_val));
    write_reg(CFG_REPEAT_TICKS, CfgDataW'(repeat_ticks_val));
    write_reg(CFG_FIRST_LONG_OFFSET, {8'($urandom), 8'(first_off)});
    write_reg(CFG_REPEAT_OFFSET, {8'($urandom), 8'(repeat_off)});
    write_reg(CFG_RELEASE_OFFSET, {8'($urandom), 8'(release_off)});
    write_reg(CfgAddrW'($urandom_range(CFG_RELEASE_OFFSET + 1, (1 << CfgAddrW) - 1)),
              CfgDataW'($urandom));
  endtask

  task automatic run_traffic(input int n);
    int sent;
    int hold;
    logic [KeyW-1:0] key;
    sent = 0;
    while (sent < n) begin
      case ($urandom_range(0, 9))
        0, 1: begin
          repeat ($urandom_range(1, 4)) begin
            send_key(KeyW'($urandom), ROW_CHECK, '0);
            sent++;
          end
        end
        2: begin
          repeat ($urandom_range(1, 3)) begin
            send_key(KEY_NONE, ROW_CHECK, '0);
            sent++;
          end
        end
        default: begin
          key = KeyW'($urandom_range(1, 7));
          if ($urandom_range(0, 1) == 0) begin
            hold = $urandom_range(0, (kp_cfg.long_press_ticks > 30) ? 30
                                     : int'(kp_cfg.long_press_ticks));
          end else begin
            hold = kp_cfg.long_press_ticks + $urandom_range(0, 4) * kp_cfg.repeat_ticks
                   + $urandom_range(0, 2);
            if (hold > HOLD_MAX) hold = HOLD_MAX;
          end
          repeat (hold + 1) send_key(key, ROW_CHECK, '0);
          if ($urandom_range(0, 3) == 0) begin
            send_key(key ^ KeyW'($urandom_range(1, 7)), ROW_CHECK, '0);
          end else begin
            send_key(KEY_NONE, ROW_CHECK, '0);
          end
          sent += hold + 2;
        end
      endcase
    end
  endtask

  task automatic report_error(input string what, input bit have_want,
                              input logic [CodeW-1:0] want_val, input logic [CodeW-1:0] got_val);
    key_errors++;
    if (key_errors <= 10) begin
      if (have_want) begin
        $display("%0t: %s: expected %0d, got %0d", $time, what, want_val, got_val);
      end else begin
        $display("%0t: %s: got %0d", $time, what, got_val);
      end
    end
  endtask

  always @(posedge clk) begin
    if (rx_left > 0) begin
      rx_left <= rx_left - 1;
    end else if (out_tready) begin
      out_tready <= 1'b0;
      rx_left <= ($urandom_range(0, 7) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 4);
    end else begin
      out_tready <= 1'b1;
      rx_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                              : $urandom_range(1, 15);
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (out_tvalid && out_tready) begin
        codes_checked++;
        if (pending_codes.size() == 0) begin
          report_error("key code transfer with nothing expected", 1'b0, '0, out_tdata);
        end else begin
          want_code = pending_codes.pop_front();
          if (out_tdata !== want_code) begin
            report_error("key code mismatch", 1'b1, want_code, out_tdata);
          end
        end
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Watchdog: no transfer for %0d cycles, %0d codes outstanding",
                 idle_cycles, pending_codes.size());
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  initial begin
    kp_cfg.long_press_ticks = LONG_PRESS_TICKS_RST;
    kp_cfg.repeat_ticks = REPEAT_TICKS_RST;
    kp_cfg.first_long_offset = FIRST_LONG_OFFSET_RST;
    kp_cfg.repeat_offset = REPEAT_OFFSET_RST;
    kp_cfg.release_offset = RELEASE_OFFSET_RST;
    press_ph = PH_IDLE;
    held_key = KEY_NONE;
    short_ticks = '0;
    long_ticks = '0;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < DIR_N; i++) begin
      if (DIR_ROWS[i].kind == ROW_REG) begin
        write_reg(DIR_ROWS[i].addr, DIR_ROWS[i].arg);
      end else begin
        send_key(DIR_ROWS[i].key, DIR_ROWS[i].kind, DIR_ROWS[i].code);
      end
    end

    set_registers(LONG_PRESS_TICKS_RST, REPEAT_TICKS_RST, FIRST_LONG_OFFSET_RST,
                  REPEAT_OFFSET_RST, RELEASE_OFFSET_RST);
    run_traffic(100);
    set_registers(1, 1, 255, 255, 255);
    run_traffic(100);
    set_registers(0, 0, 0, 0, 0);
    run_traffic(80);
    repeat (3) begin
      set_registers($urandom_range(2, 12), $urandom_range(1, 6), $urandom_range(0, 255),
                    $urandom_range(0, 255), $urandom_range(0, 255));
      run_traffic(100);
    end

    // Largest thresholds: holds stay in the short phase and end in plain codes.
    set_registers(65535, 65535, $urandom_range(0, 255), $urandom_range(0, 255),
                  $urandom_range(0, 255));
    run_traffic(30);

    set_registers($urandom_range(1, 8), $urandom_range(1, 4), $urandom_range(0, 255),
                  $urandom_range(0, 255), $urandom_range(0, 255));
    run_traffic(60);

    in_tvalid <= 1'b0;
    while (pending_codes.size() != 0) @(posedge clk);
    repeat (4 * SETTLE_CYCLES) @(posedge clk);

    $display("Covered %0d scan ticks, %0d key code transfers and %0d register writes,",
             ticks_sent, codes_checked, reg_writes);
    $display("with press thresholds from 0 to 65535 and event offsets from 0 to 255.");
    if (key_errors == 0 && pending_codes.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
